FILE: rtl/core/r0ss_pkg.sv
// ----------------------------------------------------------------------------
// r0ss_pkg
// shared constants and types of the raid0 stripe splitter
// ----------------------------------------------------------------------------
package r0ss_pkg;

    localparam int DEF_MAX_DISKS   = 16;
    localparam int DEF_OFFSET_BITS = 48;

    localparam int OFS_W    = 48;
    localparam int LEN_W    = 18;
    localparam int CLEN_W   = 21;
    localparam int DISK_W   = 4;
    localparam int SHIFT_W  = 5;
    localparam int NDISK_W  = 5;
    localparam int INSTR_W  = 20;

    localparam logic [LEN_W-1:0] MAX_LEN = 18'd258048;

    localparam logic [1:0] REG_STRIP_SHIFT = 2'd0;
    localparam logic [1:0] REG_NUM_DISKS   = 2'd1;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd20;

    // one request after normalization
    typedef struct packed {
        logic              mode;
        logic [OFS_W-1:0]  strip_no;
        logic [INSTR_W-1:0] in_strip;
        logic [LEN_W-1:0]  len;
        logic [SHIFT_W-1:0] sh;
        logic [NDISK_W-1:0] nd;
    } req_t;

    // one request after the divider
    typedef struct packed {
        logic               mode;
        logic [DISK_W-1:0]  disk;
        logic [OFS_W-1:0]   stripe;
        logic [INSTR_W-1:0] in_strip;
        logic [LEN_W-1:0]   len;
        logic [SHIFT_W-1:0] sh;
        logic [NDISK_W-1:0] nd;
    } pos_t;

endpackage

FILE: rtl/core/raid0_stripe_splitter.sv
// ----------------------------------------------------------------------------
// raid0_stripe_splitter
// splits a block request into per-strip chunks over a raid0 member set
// ----------------------------------------------------------------------------
// usage: a request beat (mode, offset, length) on the s_ channel yields one
// chunk beat per strip touched on the m_ channel, in buffer order, the final
// one marked by m_last. strip_shift and num_disks sit at apb byte addresses 0
// and 4; they must be written only while the block is idle, which the block
// itself does not enforce. pipeline: one normalize stage, seven divider
// stages (a load stage, then six stages of six quotient bits each), then
// the chunk walker and the output register.
// throughput: the walker emits one chunk per cycle while m_ready is high
// and loads the next request only after the last chunk of the current one;
// requests queue in the divider pipeline meanwhile.
// a zero length request gives no chunk.
// reset: clears all valid bits and the registers to 16 and 2.
// stall: when m_ready is low the chunk holds and the pipeline backs up
// without loss; s_ready drops once every stage is full.
// ----------------------------------------------------------------------------
module raid0_stripe_splitter
    import r0ss_pkg::*;
#(
    parameter int MAX_DISKS   = DEF_MAX_DISKS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [OFS_W-1:0]    s_request_offset,
    input  logic [LEN_W-1:0]    s_request_length,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_out_mode,
    output logic [DISK_W-1:0]   m_disk_index,
    output logic [OFS_W-1:0]    m_disk_offset,
    output logic [CLEN_W-1:0]   m_chunk_length,
    output logic [LEN_W-1:0]    m_buffer_offset,
    output logic                m_last
);
    localparam int DLIM = (MAX_DISKS < 16) ? MAX_DISKS : 16;
    localparam logic [OFS_W-1:0] OFS_MASK =
        (OFFSET_BITS >= OFS_W) ? {OFS_W{1'b1}} : OFS_W'((65'd1 << OFFSET_BITS) - 65'd1);

    logic [SHIFT_W-1:0] strip_shift_reg;
    logic [NDISK_W-1:0] num_disks_reg;

    // register file
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_shift_reg <= 5'd16;
            num_disks_reg   <= 5'd2;
        end else if (psel && penable && pwrite) begin
            case (paddr[2:2])
                REG_STRIP_SHIFT[0:0]: strip_shift_reg <= pwdata[SHIFT_W-1:0];
                REG_NUM_DISKS[0:0]:   num_disks_reg   <= pwdata[NDISK_W-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (paddr[2:2])
                REG_STRIP_SHIFT[0:0]: prdata = {27'd0, strip_shift_reg};
                REG_NUM_DISKS[0:0]:   prdata = {27'd0, num_disks_reg};
                default:              prdata = '0;
            endcase
        end
    end

    // effective settings
    logic [SHIFT_W-1:0] eff_sh;
    logic [NDISK_W-1:0] eff_nd;
    always_comb begin
        eff_sh = strip_shift_reg;
        if (eff_sh < SHIFT_MIN) eff_sh = SHIFT_MIN;
        if (eff_sh > SHIFT_MAX) eff_sh = SHIFT_MAX;
        eff_nd = num_disks_reg;
        if (eff_nd == '0) eff_nd = 5'd1;
        if (eff_nd > NDISK_W'(DLIM)) eff_nd = NDISK_W'(DLIM);
    end

    // normalize stage: mask offset, clamp length, split at the strip boundary
    logic               n_vld_reg;
    req_t               n_req_reg;
    logic               d_in_ready;
    logic               n_adv;
    logic [OFS_W-1:0]   ofs_m;
    assign n_adv   = d_in_ready || !n_vld_reg;
    assign s_ready = n_adv;
    assign ofs_m   = s_request_offset & OFS_MASK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_vld_reg <= 1'b0;
        end else if (n_adv) begin
            n_vld_reg <= s_valid && (s_request_length != '0);
        end
    end
    always_ff @(posedge aclk) begin
        if (n_adv && s_valid) begin
            n_req_reg.mode     <= s_mode;
            n_req_reg.strip_no <= ofs_m >> eff_sh;
            n_req_reg.in_strip <= ofs_m[INSTR_W-1:0] &
                                  INSTR_W'((21'd1 << eff_sh) - 21'd1);
            n_req_reg.len      <= (s_request_length > MAX_LEN) ? MAX_LEN : s_request_length;
            n_req_reg.sh       <= eff_sh;
            n_req_reg.nd       <= eff_nd;
        end
    end

    // division of strip number into disk and stripe
    logic d_out_valid;
    logic d_out_ready;
    pos_t d_pos;
    r0ss_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (n_vld_reg),
        .in_ready  (d_in_ready),
        .in_req    (n_req_reg),
        .out_valid (d_out_valid),
        .out_ready (d_out_ready),
        .out_pos   (d_pos)
    );

    // chunk walker: one chunk per beat
    logic               busy_reg;
    logic               mode_reg;
    logic [DISK_W-1:0]  disk_reg;
    logic [OFS_W-1:0]   stripe_reg;
    logic [INSTR_W-1:0] in_strip_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   done_reg;
    logic [SHIFT_W-1:0] sh_reg;
    logic [NDISK_W-1:0] nd_reg;
    logic [CLEN_W-1:0]  room;
    logic [CLEN_W-1:0]  left;
    logic [CLEN_W-1:0]  cl;
    logic               fin;
    logic               fire;
    logic [DISK_W:0]    disk_inc;

    assign d_out_ready = !busy_reg;
    assign room = CLEN_W'(21'd1 << sh_reg) - CLEN_W'(in_strip_reg);
    assign left = CLEN_W'(len_reg) - CLEN_W'(done_reg);
    assign cl   = (room < left) ? room : left;
    assign fin  = (cl == left);
    assign fire = busy_reg && (!m_valid || m_ready);
    assign disk_inc = {1'b0, disk_reg} + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (!busy_reg) begin
            busy_reg <= d_out_valid;
        end else if (fire && fin) begin
            busy_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (!busy_reg && d_out_valid) begin
            mode_reg     <= d_pos.mode;
            disk_reg     <= d_pos.disk;
            stripe_reg   <= d_pos.stripe;
            in_strip_reg <= d_pos.in_strip;
            len_reg      <= d_pos.len;
            done_reg     <= '0;
            sh_reg       <= d_pos.sh;
            nd_reg       <= d_pos.nd;
        end else if (fire && !fin) begin
            done_reg     <= done_reg + cl[LEN_W-1:0];
            in_strip_reg <= '0;
            if (NDISK_W'(disk_inc) >= nd_reg) begin
                disk_reg   <= '0;
                stripe_reg <= stripe_reg + OFS_W'(1);
            end else begin
                disk_reg   <= disk_inc[DISK_W-1:0];
            end
        end
    end

    // output register
    logic               m_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_out_mode      <= mode_reg;
            m_disk_index    <= disk_reg;
            m_disk_offset   <= ((stripe_reg << sh_reg) + OFS_W'(in_strip_reg)) & OFS_MASK;
            m_chunk_length  <= cl;
            m_buffer_offset <= done_reg;
            m_last          <= fin;
        end
    end
    assign m_valid = m_valid_reg;

    // checks
    a_len_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (len_reg > done_reg)) else $error("walker past end");
    a_disk_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> ({1'b0, disk_reg} < nd_reg)) else $error("disk out of range");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("beat dropped");
    a_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_chunk_length != '0)) else $error("empty chunk");

endmodule

FILE: rtl/core/r0ss_div.sv
// ----------------------------------------------------------------------------
// r0ss_div
// pipelined restoring divider of the strip number by the disk count,
// a load stage followed by register stages of BPS quotient bits each
// ----------------------------------------------------------------------------
module r0ss_div
    import r0ss_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  req_t  in_req,
    output logic  out_valid,
    input  logic  out_ready,
    output pos_t  out_pos
);
    localparam int QB    = 36;   // quotient bits: strip_no < 2^36
    localparam int BPS   = 6;    // bits per stage
    localparam int NST   = QB / BPS;

    typedef struct packed {
        logic               mode;
        logic [QB-1:0]      num;
        logic [NDISK_W-1:0] rem;
        logic [INSTR_W-1:0] in_strip;
        logic [LEN_W-1:0]   len;
        logic [SHIFT_W-1:0] sh;
        logic [NDISK_W-1:0] nd;
    } dstg_t;

    dstg_t             stg_reg [NST+1];
    logic [NST:0]      vld_reg;
    logic [NST:0]      adv;
    dstg_t             stg_next [NST+1];

    // stage advance: a stage moves when the next one is free or moving
    always_comb begin
        adv[NST] = out_ready || !vld_reg[NST];
        for (int i = NST - 1; i >= 0; i--) begin
            adv[i] = adv[i+1] || !vld_reg[i];
        end
    end
    assign in_ready = adv[0];

    // load and per-stage quotient bits
    always_comb begin
        logic [NDISK_W:0] r;
        stg_next[0].mode     = in_req.mode;
        stg_next[0].num      = in_req.strip_no[QB-1:0];
        stg_next[0].rem      = '0;
        stg_next[0].in_strip = in_req.in_strip;
        stg_next[0].len      = in_req.len;
        stg_next[0].sh       = in_req.sh;
        stg_next[0].nd       = in_req.nd;
        for (int s = 1; s <= NST; s++) begin
            stg_next[s] = stg_reg[s-1];
            for (int b = 0; b < BPS; b++) begin
                r = {stg_next[s].rem, stg_next[s].num[QB-1]};
                stg_next[s].num = {stg_next[s].num[QB-2:0], 1'b0};
                if (r >= {1'b0, stg_next[s].nd}) begin
                    r = r - {1'b0, stg_next[s].nd};
                    stg_next[s].num[0] = 1'b1;
                end
                stg_next[s].rem = r[NDISK_W-1:0];
            end
        end
    end

    // stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg[0] <= adv[0] ? in_valid : vld_reg[0];
            for (int s = 1; s <= NST; s++) begin
                if (adv[s]) vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0] && in_valid) stg_reg[0] <= stg_next[0];
        for (int s = 1; s <= NST; s++) begin
            if (adv[s] && vld_reg[s-1]) stg_reg[s] <= stg_next[s];
        end
    end

    assign out_valid         = vld_reg[NST];
    assign out_pos.mode      = stg_reg[NST].mode;
    assign out_pos.disk      = stg_reg[NST].rem[DISK_W-1:0];
    assign out_pos.stripe    = {{(OFS_W-QB){1'b0}}, stg_reg[NST].num};
    assign out_pos.in_strip  = stg_reg[NST].in_strip;
    assign out_pos.len       = stg_reg[NST].len;
    assign out_pos.sh        = stg_reg[NST].sh;
    assign out_pos.nd        = stg_reg[NST].nd;

endmodule
